### rtl/sensor_scratchpad_crc_checker_top_assert.svh
// assertion macros for the scratchpad crc checker
// used by sensor_scratchpad_crc_checker_top; expects clk and rst in scope
`ifndef SENSOR_SCRATCHPAD_CRC_CHECKER_TOP_ASSERT_SVH
`define SENSOR_SCRATCHPAD_CRC_CHECKER_TOP_ASSERT_SVH

// condition in this cycle implies consequence in this cycle
`define SSCC_ASSERT_NOW(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// condition in this cycle implies consequence in the next cycle
`define SSCC_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sscc_pkg.sv
// shared constants, types and the crc-8 update for the scratchpad crc checker
// no dependencies
package sscc_pkg;

  localparam int FRAME_BYTES_DEF = 9;
  localparam int POS_W           = 4;

  localparam logic [7:0]  CRC_POLY   = 8'h8C;
  localparam logic [15:0] SIGN_MASK  = 16'hF800;
  localparam logic [15:0] INT_MASK   = 16'h07F0;
  localparam logic [15:0] FRAC_MASK  = 16'h000F;
  localparam logic [9:0]  FRAC_SCALE = 10'd625;

  // frame result handed from the frame tracker to the output stage
  typedef struct packed {
    logic [15:0] raw;
    logic        crc_error;
  } frame_res_t;

  // one byte of the reflected 1-wire crc, bit by bit
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### rtl/sscc_frame.sv
// frame position, running crc and temperature bytes of one scratchpad frame
// depends on sscc_pkg
module sscc_frame #(
  parameter int FRAME_BYTES = sscc_pkg::FRAME_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           rx_byte,
  input  logic                 frame_start,
  output logic                 hit,
  output sscc_pkg::frame_res_t res
);

  localparam logic [sscc_pkg::POS_W-1:0] LAST_POS =
    sscc_pkg::POS_W'(FRAME_BYTES - 1);
  localparam logic [sscc_pkg::POS_W-1:0] END_POS = sscc_pkg::POS_W'(FRAME_BYTES);

  logic [sscc_pkg::POS_W-1:0] byte_position, byte_position_next;
  logic [7:0] running_crc, running_crc_next;
  logic [7:0] temp_low_byte, temp_high_byte;
  logic [sscc_pkg::POS_W-1:0] pos_eff;
  logic [7:0] crc_eff;
  logic       live;

  // start flag restarts position and crc before the byte is taken
  assign pos_eff = frame_start ? '0 : byte_position;
  assign crc_eff = frame_start ? 8'h00 : running_crc;
  assign live    = (pos_eff < END_POS);
  assign hit     = live && (pos_eff == LAST_POS);

  assign res.raw       = {temp_high_byte, temp_low_byte};
  assign res.crc_error = (crc_eff != rx_byte);

  // next position and crc
  always_comb begin
    byte_position_next = byte_position;
    running_crc_next   = running_crc;
    if (frame_start) begin
      byte_position_next = '0;
      running_crc_next   = 8'h00;
    end
    if (live) begin
      if (hit) begin
        byte_position_next = END_POS;
      end else begin
        byte_position_next = pos_eff + 1'b1;
        running_crc_next   = sscc_pkg::crc8_update(crc_eff, rx_byte);
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      running_crc   <= 8'h00;
    end else if (step) begin
      byte_position <= byte_position_next;
      running_crc   <= running_crc_next;
    end
  end

  // temperature bytes, reset to zero as they are visible without a frame
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_low_byte  <= 8'h00;
      temp_high_byte <= 8'h00;
    end else if (step && live) begin
      if (pos_eff == '0) begin
        temp_low_byte <= rx_byte;
      end else if (pos_eff == sscc_pkg::POS_W'(1)) begin
        temp_high_byte <= rx_byte;
      end
    end
  end

endmodule

### rtl/sensor_scratchpad_crc_checker_top.sv
// Scratchpad CRC checker: takes scratchpad bytes on the input channel, gives
// one decoded temperature result per frame on the output channel.
// Input channel: in_valid / in_stall with rx_byte and frame_start. A transfer
// happens on a rising edge with in_valid high and in_stall low. frame_start
// marks byte zero of a frame; without it, bytes continue the current frame.
// Output channel: out_valid / out_stall with temperature_raw, crc_error,
// sign_negative, integer_part and fraction_part, one result per frame.
// The CRC-8 (reflected 0x8C, init 0) covers bytes 0 to FRAME_BYTES-2 and is
// compared with the last byte; bytes after the last give nothing until the
// next start.
// Each byte passes the input register, and a result then the result register.
// Throughput: one byte per cycle while in_stall is low, as the byte-wide CRC
// update between the two registers is combinational.
// When out_stall holds a result, bytes that give no result keep flowing; a
// byte that would give a result waits in the input register and in_stall
// rises only then.
// Reset: synchronous rst empties both registers, sets the frame position to
// byte zero and clears the CRC and temperature bytes.
// Depends on sscc_pkg, sscc_frame and the assertion header.
`include "sensor_scratchpad_crc_checker_top_assert.svh"

module sensor_scratchpad_crc_checker_top #(
  parameter int FRAME_BYTES = sscc_pkg::FRAME_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  input  logic               frame_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] temperature_raw,
  output logic               crc_error,
  output logic               sign_negative,
  output logic [6:0]         integer_part,
  output logic [13:0]        fraction_part
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_start;
  logic       s1_advance, s1_fire, in_fire, res_load;
  logic       hit;
  sscc_pkg::frame_res_t fres;
  logic [15:0] mag;
  logic [13:0] frac_next;

  // a result-bearing byte waits only while the result register is held
  assign s1_advance = !(hit && out_valid && out_stall);
  assign s1_fire    = s1_valid && s1_advance;
  assign in_stall   = s1_valid && !s1_advance;
  assign in_fire    = in_valid && !in_stall;
  assign res_load   = s1_fire && hit;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte  <= rx_byte;
      s1_start <= frame_start;
    end
  end

  sscc_frame #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_frame (
    .clk         (clk),
    .rst         (rst),
    .step        (s1_fire),
    .rx_byte     (s1_byte),
    .frame_start (s1_start),
    .hit         (hit),
    .res         (fres)
  );

  // magnitude of the temperature word and fraction in ten-thousandths
  assign mag       = fres.raw[15] ? (16'h0000 - fres.raw) : fres.raw;
  assign frac_next = {10'd0, mag[3:0]} * {4'd0, sscc_pkg::FRAC_SCALE};

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (res_load) begin
      temperature_raw <= signed'(fres.raw);
      crc_error       <= fres.crc_error;
      sign_negative   <= |(fres.raw & sscc_pkg::SIGN_MASK);
      integer_part    <= 7'((mag & sscc_pkg::INT_MASK) >> 4);
      fraction_part   <= frac_next;
    end
  end

  // checks on the pipeline control
  `SSCC_ASSERT_NEXT(a_hit_gives_result, res_load, out_valid, "frame result not presented")
  `SSCC_ASSERT_NOW(a_stall_only_on_hit, in_stall, s1_valid && hit && out_valid && out_stall, "input stalled without a held result")
  `SSCC_ASSERT_NEXT(a_result_drains, out_valid && !out_stall && !res_load, !out_valid, "result repeated after transfer")

endmodule

### tb/sv/sensor_scratchpad_crc_checker_top_tb.sv
// testbench for the scratchpad crc checker: byte driver, result monitor and predictor
// depends on sscc_pkg and sensor_scratchpad_crc_checker_top
module sensor_scratchpad_crc_checker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_LEN   = sscc_pkg::FRAME_BYTES_DEF;
  localparam int HOLD_CYCLES = 250;

  typedef struct {
    logic [7:0] data;
    logic       start;
  } scratch_byte_t;

  typedef struct {
    logic [15:0] raw;
    logic        crc_err;
    logic        neg;
    logic [6:0]  int_part;
    logic [13:0] frac;
  } reading_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         rx_byte = 8'h00;
  logic               frame_start = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] temperature_raw;
  logic               crc_error;
  logic               sign_negative;
  logic [6:0]         integer_part;
  logic [13:0]        fraction_part;

  scratch_byte_t bytes_to_send[$];
  reading_t      expected_readings[$];

  // predictor state, mirrors the frame tracker
  logic [3:0] pos = 4'd0;
  logic [7:0] crc_acc = 8'h00;
  logic [7:0] t_lo = 8'h00;
  logic [7:0] t_hi = 8'h00;

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  logic hold_trig = 1'b0;
  int hold_left = 0;

  int failures = 0;
  int bytes_sent = 0;
  int readings_checked = 0;
  int crc_errs_seen = 0;
  int negatives_seen = 0;

  sensor_scratchpad_crc_checker_top uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .rx_byte         (rx_byte),
    .frame_start     (frame_start),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .temperature_raw (temperature_raw),
    .crc_error       (crc_error),
    .sign_negative   (sign_negative),
    .integer_part    (integer_part),
    .fraction_part   (fraction_part)
  );

  always #5 clk = ~clk;

  // 1-wire crc-8, one data bit at a time, lsb first
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] d);
    logic [7:0] r;
    logic       fb;
    r = crc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ d[i];
      r  = r >> 1;
      if (fb) begin
        r = r ^ sscc_pkg::CRC_POLY;
      end
    end
    return r;
  endfunction

  // frame tracking and decode of one accepted byte
  task automatic predict_reading(input logic [7:0] d, input logic s);
    reading_t    r;
    logic [16:0] mag;
    if (s) begin
      pos     = 4'd0;
      crc_acc = 8'h00;
    end
    if (pos >= FRAME_LEN) return;
    if (pos == 0) t_lo = d;
    else if (pos == 1) t_hi = d;
    if (pos < FRAME_LEN - 1) begin
      crc_acc = crc8_next(crc_acc, d);
      pos     = pos + 4'd1;
      return;
    end
    pos        = 4'(FRAME_LEN);
    r.raw      = {t_hi, t_lo};
    mag        = r.raw[15] ? (17'h10000 - {1'b0, r.raw}) : {1'b0, r.raw};
    r.crc_err  = (crc_acc != d);
    r.neg      = |(r.raw & sscc_pkg::SIGN_MASK);
    r.int_part = mag[10:4];
    r.frac     = 14'(int'(mag[3:0]) * int'(sscc_pkg::FRAC_SCALE));
    expected_readings.push_back(r);
  endtask

  function automatic void check_field(string fname, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", fname, want, got);
      failures++;
    end
  endfunction

  // driver: offers queued bytes, holds the payload while stalled
  always @(posedge clk) begin
    scratch_byte_t item;
    if (rst) begin
      in_valid    <= 1'b0;
      rx_byte     <= 8'h00;
      frame_start <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_reading(rx_byte, frame_start);
        bytes_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (bytes_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          item = bytes_to_send.pop_front();
          in_valid    <= 1'b1;
          rx_byte     <= item.data;
          frame_start <= item.start;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_trig) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: checks each result transfer against the oldest expectation
  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          $error("result transfer with no expectation: raw 0x%0h", temperature_raw);
          failures++;
        end else begin
          want = expected_readings.pop_front();
          check_field("temperature_raw", want.raw, temperature_raw);
          check_field("crc_error", 16'(want.crc_err), 16'(crc_error));
          check_field("sign_negative", 16'(want.neg), 16'(sign_negative));
          check_field("integer_part", 16'(want.int_part), 16'(integer_part));
          check_field("fraction_part", 16'(want.frac), 16'(fraction_part));
          readings_checked++;
          crc_errs_seen  += int'(crc_error);
          negatives_seen += int'(sign_negative);
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // queue a frame, or the first n_bytes of one; temperature in bytes zero and one
  task automatic push_frame(input logic first_start, input logic [15:0] t_word,
                            input logic good_crc, input int n_bytes);
    logic [7:0] b;
    logic [7:0] crc;
    scratch_byte_t item;
    crc = 8'h00;
    for (int i = 0; i < n_bytes; i++) begin
      if (i == 0) b = t_word[7:0];
      else if (i == 1) b = t_word[15:8];
      else if (i == FRAME_LEN - 1) b = good_crc ? crc : crc ^ 8'($urandom_range(1, 255));
      else b = 8'($urandom);
      if (i < FRAME_LEN - 1) crc = crc8_next(crc, b);
      item.data  = b;
      item.start = (i == 0) ? first_start : 1'b0;
      bytes_to_send.push_back(item);
    end
  endtask

  function automatic logic [15:0] pick_temperature();
    logic [15:0] corners[15] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h07FF,
                                 16'hF800, 16'h0800, 16'h8001, 16'hFC90, 16'h0550,
                                 16'h0191, 16'hFF5E, 16'h000F, 16'h07F0, 16'hF7FF};
    if ($urandom_range(99) < 35) return corners[$urandom_range(14)];
    return 16'($urandom);
  endfunction

  // mostly clean frames, some cut short, some trailing bytes and stray noise
  task automatic push_random_stream(input int n_items);
    int pushed;
    int kind;
    int n;
    scratch_byte_t item;
    pushed = 0;
    while (pushed < n_items) begin
      kind = $urandom_range(99);
      if (kind < 75) begin
        push_frame(1'b1, pick_temperature(), $urandom_range(99) < 85, FRAME_LEN);
        pushed += FRAME_LEN;
      end else if (kind < 87) begin
        n = $urandom_range(1, FRAME_LEN - 1);
        push_frame(1'b1, pick_temperature(), 1'b1, n);
        pushed += n;
      end else if (kind < 94) begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
          item.data  = 8'($urandom);
          item.start = 1'b0;
          bytes_to_send.push_back(item);
        end
        pushed += n;
      end else begin
        item.data  = 8'($urandom);
        item.start = 1'($urandom);
        bytes_to_send.push_back(item);
        pushed++;
      end
    end
  endtask

  task automatic wait_drained();
    while (bytes_to_send.size() != 0 || in_valid || expected_readings.size() != 0)
      @(negedge clk);
  endtask

  // stimulus sequencing
  initial begin
    scratch_byte_t item;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: first frame without a start flag, 0x8000 reading
    push_frame(1'b0, 16'h8000, 1'b1, FRAME_LEN);
    // bytes past the end of the frame are ignored
    for (int i = 0; i < 2; i++) begin
      item.data  = 8'hFF;
      item.start = 1'b0;
      bytes_to_send.push_back(item);
    end
    // frame restarted part way through, then a full one with a bad crc
    push_frame(1'b1, 16'h07FF, 1'b1, 3);
    push_frame(1'b1, 16'h7FFF, 1'b0, FRAME_LEN);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 48; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 48; end
        default: begin sender_idle_pct = 12; receiver_stall_pct = 12; end
      endcase
      push_random_stream(300);
      wait_drained();

      if (ph == 0) begin
        // receiver holds off while frames keep coming, so the input backs up
        for (int f = 0; f < 5; f++) push_frame(1'b1, pick_temperature(), 1'b1, FRAME_LEN);
        hold_trig = 1'b1;
        @(negedge clk);
        hold_trig = 1'b0;
        // sender then waits for every result before going on
        wait_drained();
      end
    end

    repeat (10) @(posedge clk);
    $display("sent %0d bytes, checked %0d readings (%0d with crc mismatch, %0d negative)",
             bytes_sent, readings_checked, crc_errs_seen, negatives_seen);
    $display("covered idle and stall mixes, a long output hold-off and cut-short frames");
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #3000000;
    $display("simulation failed");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/sscc_pkg.sv
rtl/sscc_frame.sv
rtl/sensor_scratchpad_crc_checker_top.sv
tb/sv/sensor_scratchpad_crc_checker_top_tb.sv
